// ===== design/mtk_pkg.sv =====
// Package for the Morse text keyer: opcodes, keyer phases, controller states,
// datapath commands, status bundle, register map, dot timing and character table.
// No dependencies.
package mtk_pkg;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_APPEND = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_WAIT = 3'd1,
        PH_MARK = 3'd2,
        PH_EGAP = 3'd3,
        PH_CGAP = 3'd4,
        PH_WGAP = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_SCAN,
        CS_SPACE_FIRST,
        CS_SPACE_RUN,
        CS_CAPTURE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_APPEND,
        DP_CLEAR,
        DP_START,
        DP_REFUSE,
        DP_PTT_OFF,
        DP_FINISH,
        DP_WAIT_TICK,
        DP_KEY_LOST,
        DP_TICK_DEC,
        DP_MARK_END,
        DP_BEGIN_ELEM,
        DP_POS_INC,
        DP_BEGIN_CHAR,
        DP_CGAP,
        DP_WGAP
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
        logic   capture;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       tx_active;
        logic       tx_ended;
        phase_t     phase;
        logic       count_zero;
        logic       count_full;
        logic       tick_expire;
        logic       elem_last;
        logic       pos_in;
        logic       char_valid;
        logic       char_space;
        logic       out_free;
    } dp_status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] pattern;
    } morse_t;

    localparam logic REG_WPM = 1'b0;
    localparam logic REG_CW  = 1'b1;

    localparam logic [4:0] WPM_RESET        = 5'd18;
    localparam logic [6:0] START_WAIT_TICKS = 7'd100;
    localparam logic [6:0] CHAR_SPACE       = 7'h20;

    localparam logic [7:0] MORSE_TABLE [36] = '{
        8'h21, 8'h68, 8'h6A, 8'h44, 8'h00, 8'h62, 8'h46, 8'h60, 8'h20, 8'h67,
        8'h45, 8'h64, 8'h23, 8'h22, 8'h47, 8'h66, 8'h6D, 8'h42, 8'h40, 8'h01,
        8'h41, 8'h61, 8'h43, 8'h69, 8'h6B, 8'h6C,
        8'h9F, 8'h8F, 8'h87, 8'h83, 8'h81, 8'h80, 8'h90, 8'h98, 8'h9C, 8'h9E
    };

    function automatic logic [6:0] fold_case(input logic [6:0] code);
        fold_case = (code inside {[7'h61:7'h7A]}) ? code - 7'd32 : code;
    endfunction

    function automatic morse_t char_pattern(input logic [6:0] code);
        logic [6:0] up;
        morse_t     r;
        up = fold_case(code);
        r.valid = 1'b1;
        r.pattern = 8'h00;
        if (up inside {[7'h41:7'h5A]}) begin
            r.pattern = MORSE_TABLE[6'(up - 7'h41)];
        end
        else if (up inside {[7'h30:7'h39]}) begin
            r.pattern = MORSE_TABLE[6'(up - 7'h30 + 7'd26)];
        end
        else begin
            r.valid = 1'b0;
        end
        char_pattern = r;
    endfunction

    // (120 + wpm/2) / wpm with wpm held to 5..30
    function automatic logic [4:0] dot_ticks(input logic [4:0] wpm);
        case (wpm) inside
            [5'd0:5'd5]:   dot_ticks = 5'd24;
            5'd6:          dot_ticks = 5'd20;
            5'd7:          dot_ticks = 5'd17;
            5'd8:          dot_ticks = 5'd15;
            5'd9:          dot_ticks = 5'd13;
            5'd10:         dot_ticks = 5'd12;
            5'd11:         dot_ticks = 5'd11;
            5'd12:         dot_ticks = 5'd10;
            [5'd13:5'd14]: dot_ticks = 5'd9;
            [5'd15:5'd16]: dot_ticks = 5'd8;
            [5'd17:5'd18]: dot_ticks = 5'd7;
            [5'd19:5'd21]: dot_ticks = 5'd6;
            [5'd22:5'd26]: dot_ticks = 5'd5;
            default:       dot_ticks = 5'd4;
        endcase
    endfunction

endpackage

// ===== design/morse_text_keyer.sv =====
// Morse text keyer top level: APB registers, controller and datapath.
// Each transaction is decoded, then scans the text store when a tick starts a character
// or skips spaces, one store position per cycle, and its result is then registered.
// A new transaction is accepted only after the last result is captured, and capture
// waits while the output still holds a result that has not been taken.
// Reset: keyer idle, text empty, 18 wpm, CW mode on; store contents are not cleared.
module morse_text_keyer #(
    parameter int TEXT_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_code[6:0], tx_active, tx_ended, zeros
    input  logic [2:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // carrier_on, sending, ptt_on_request, ptt_off_request,
                                   // tx_rejected, refused, text_length[5:0], zeros
);

    logic [4:0]          wpm;
    logic                cw_en;
    mtk_pkg::ctrl_cmd_t  cmd;
    mtk_pkg::dp_status_t status;

    mtk_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .words_per_minute (wpm),
        .cw_mode_enabled  (cw_en)
    );

    mtk_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .cw_mode_enabled (cw_en),
        .status          (status),
        .cmd             (cmd)
    );

    mtk_dp #(
        .TEXT_DEPTH (TEXT_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .words_per_minute (wpm),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

// ===== design/mtk_cfg.sv =====
// APB register file of the Morse text keyer: speed and CW mode enable.
// Depends on mtk_pkg.
module mtk_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [4:0]  words_per_minute,
    output logic        cw_mode_enabled
);

    logic [4:0] wpm_reg;
    logic       cw_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpm_reg <= mtk_pkg::WPM_RESET;
            cw_reg  <= 1'b1;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                mtk_pkg::REG_WPM: wpm_reg <= pwdata[4:0];
                mtk_pkg::REG_CW:  cw_reg  <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mtk_pkg::REG_WPM: prdata = {27'd0, wpm_reg};
            mtk_pkg::REG_CW:  prdata = {31'd0, cw_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign words_per_minute = wpm_reg;
    assign cw_mode_enabled  = cw_reg;

endmodule

// ===== design/mtk_ctrl.sv =====
// Controller of the Morse text keyer: sequences one transaction through
// decode, store scans and result capture. Depends on mtk_pkg.
module mtk_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   cw_mode_enabled,
    input  mtk_pkg::dp_status_t    status,
    output mtk_pkg::ctrl_cmd_t     cmd
);

    mtk_pkg::ctrl_state_t state_reg;
    mtk_pkg::ctrl_state_t state_next;
    logic                 busy;
    logic                 lost;
    logic                 space_hit;

    assign busy      = (status.phase != mtk_pkg::PH_IDLE);
    assign lost      = !status.tx_active || status.tx_ended;
    assign space_hit = status.pos_in && status.char_space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtk_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtk_pkg::CS_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mtk_pkg::CS_EXEC;
                end
            end
            mtk_pkg::CS_EXEC:
            begin
                state_next = mtk_pkg::CS_CAPTURE;
                if (status.op == mtk_pkg::OP_TICK)
                begin
                    case (status.phase)
                        mtk_pkg::PH_IDLE: ;
                        mtk_pkg::PH_WAIT:
                        begin
                            if (status.tx_active)
                            begin
                                state_next = mtk_pkg::CS_SCAN;
                            end
                        end
                        default:
                        begin
                            if (!lost && status.tick_expire)
                            begin
                                if (status.phase == mtk_pkg::PH_MARK)
                                begin
                                    if (status.elem_last)
                                    begin
                                        state_next = mtk_pkg::CS_SPACE_FIRST;
                                    end
                                end
                                else if (status.phase != mtk_pkg::PH_EGAP)
                                begin
                                    state_next = mtk_pkg::CS_SCAN;
                                end
                            end
                        end
                    endcase
                end
            end
            mtk_pkg::CS_SCAN:
            begin
                if (!status.pos_in || status.char_valid)
                begin
                    state_next = mtk_pkg::CS_CAPTURE;
                end
            end
            mtk_pkg::CS_SPACE_FIRST:
            begin
                state_next = space_hit ? mtk_pkg::CS_SPACE_RUN : mtk_pkg::CS_CAPTURE;
            end
            mtk_pkg::CS_SPACE_RUN:
            begin
                if (!space_hit)
                begin
                    state_next = mtk_pkg::CS_CAPTURE;
                end
            end
            mtk_pkg::CS_CAPTURE:
            begin
                if (status.out_free)
                begin
                    state_next = mtk_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = mtk_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load    = 1'b0;
        cmd.op      = mtk_pkg::DP_NONE;
        cmd.capture = 1'b0;
        s_tready    = 1'b0;
        case (state_reg)
            mtk_pkg::CS_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            mtk_pkg::CS_EXEC:
            begin
                case (status.op)
                    mtk_pkg::OP_TICK:
                    begin
                        case (status.phase)
                            mtk_pkg::PH_IDLE: ;
                            mtk_pkg::PH_WAIT:
                            begin
                                if (!status.tx_active)
                                begin
                                    cmd.op = mtk_pkg::DP_WAIT_TICK;
                                end
                            end
                            default:
                            begin
                                if (lost)
                                begin
                                    cmd.op = mtk_pkg::DP_KEY_LOST;
                                end
                                else if (!status.tick_expire)
                                begin
                                    cmd.op = mtk_pkg::DP_TICK_DEC;
                                end
                                else if (status.phase == mtk_pkg::PH_MARK)
                                begin
                                    cmd.op = mtk_pkg::DP_MARK_END;
                                end
                                else if (status.phase == mtk_pkg::PH_EGAP)
                                begin
                                    cmd.op = mtk_pkg::DP_BEGIN_ELEM;
                                end
                                else
                                begin
                                    cmd.op = mtk_pkg::DP_TICK_DEC;
                                end
                            end
                        endcase
                    end
                    mtk_pkg::OP_APPEND:
                    begin
                        if (!busy)
                        begin
                            cmd.op = status.count_full ? mtk_pkg::DP_REFUSE
                                                       : mtk_pkg::DP_APPEND;
                        end
                    end
                    mtk_pkg::OP_CLEAR:
                    begin
                        if (!busy)
                        begin
                            cmd.op = mtk_pkg::DP_CLEAR;
                        end
                    end
                    mtk_pkg::OP_START:
                    begin
                        if (status.count_zero || busy || !cw_mode_enabled)
                        begin
                            cmd.op = mtk_pkg::DP_REFUSE;
                        end
                        else
                        begin
                            cmd.op = mtk_pkg::DP_START;
                        end
                    end
                    mtk_pkg::OP_STOP:
                    begin
                        if (status.tx_active)
                        begin
                            cmd.op = status.tx_ended ? mtk_pkg::DP_PTT_OFF
                                                     : mtk_pkg::DP_FINISH;
                        end
                        else if (busy)
                        begin
                            cmd.op = mtk_pkg::DP_FINISH;
                        end
                    end
                    default: ;
                endcase
            end
            mtk_pkg::CS_SCAN:
            begin
                if (!status.pos_in)
                begin
                    cmd.op = mtk_pkg::DP_FINISH;
                end
                else if (status.char_valid)
                begin
                    cmd.op = mtk_pkg::DP_BEGIN_CHAR;
                end
                else
                begin
                    cmd.op = mtk_pkg::DP_POS_INC;
                end
            end
            mtk_pkg::CS_SPACE_FIRST:
            begin
                cmd.op = space_hit ? mtk_pkg::DP_POS_INC : mtk_pkg::DP_CGAP;
            end
            mtk_pkg::CS_SPACE_RUN:
            begin
                cmd.op = space_hit ? mtk_pkg::DP_POS_INC : mtk_pkg::DP_WGAP;
            end
            mtk_pkg::CS_CAPTURE:
            begin
                cmd.capture = status.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== design/mtk_dp.sv =====
// Datapath of the Morse text keyer: text store, keyer state, timing counters
// and the result register. Depends on mtk_pkg.
module mtk_dp #(
    parameter int TEXT_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         s_tdata,   // char_code[6:0], tx_active, tx_ended, zeros
    input  logic [2:0]          s_tuser,   // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // carrier_on, sending, ptt_on_request,
                                           // ptt_off_request, tx_rejected, refused,
                                           // text_length[5:0], zeros
    input  logic [4:0]          words_per_minute,
    input  mtk_pkg::ctrl_cmd_t  cmd,
    output mtk_pkg::dp_status_t status
);

    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int CW = $clog2(TEXT_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TEXT_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [6:0]      mem [TEXT_DEPTH];
    logic [6:0]      rd_data_reg;

    logic [2:0]      item_op_reg;
    logic [6:0]      item_char_reg;
    logic            item_act_reg;
    logic            item_end_reg;

    mtk_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [7:0]      pattern_reg, pattern_next;
    logic [2:0]      num_reg, num_next;
    logic [2:0]      total_reg, total_next;
    logic [7:0]      tick_reg, tick_next;
    logic [6:0]      wait_reg, wait_next;
    logic            rejected_reg, rejected_next;
    logic            keyed_reg, keyed_next;
    logic            ptt_on_reg, ptt_on_next;
    logic            ptt_off_reg, ptt_off_next;
    logic            refused_reg, refused_next;
    logic            out_valid_reg;
    logic [15:0]     out_data_reg;

    mtk_pkg::morse_t rd_morse;
    logic [7:0]      dot1;
    logic [7:0]      dot3;
    logic [7:0]      dot7;
    logic [2:0]      elem_shift;
    logic            elem_dash;
    logic            char_dash;
    logic            elem_last;

    assign rd_morse   = mtk_pkg::char_pattern(rd_data_reg);
    assign dot1       = {3'd0, mtk_pkg::dot_ticks(words_per_minute)};
    assign dot3       = dot1 + (dot1 << 1);
    assign dot7       = (dot1 << 3) - dot1;
    assign elem_shift = total_reg - 3'd1 - num_reg;
    assign elem_dash  = pattern_reg[elem_shift];
    assign char_dash  = rd_morse.pattern[rd_morse.pattern[7:5]];
    assign elem_last  = ({1'b0, num_reg} + 4'd1) >= {1'b0, total_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        pattern_next  = pattern_reg;
        num_next      = num_reg;
        total_next    = total_reg;
        tick_next     = tick_reg;
        wait_next     = wait_reg;
        rejected_next = rejected_reg;
        keyed_next    = keyed_reg;
        ptt_on_next   = ptt_on_reg;
        ptt_off_next  = ptt_off_reg;
        refused_next  = refused_reg;
        if (cmd.load)
        begin
            ptt_on_next  = 1'b0;
            ptt_off_next = 1'b0;
            refused_next = 1'b0;
        end
        case (cmd.op)
            mtk_pkg::DP_NONE: ;
            mtk_pkg::DP_APPEND:
            begin
                count_next = count_reg + ONE_C;
            end
            mtk_pkg::DP_CLEAR:
            begin
                count_next = '0;
            end
            mtk_pkg::DP_START:
            begin
                pos_next      = '0;
                rejected_next = 1'b0;
                phase_next    = mtk_pkg::PH_WAIT;
                wait_next     = mtk_pkg::START_WAIT_TICKS;
                ptt_on_next   = 1'b1;
            end
            mtk_pkg::DP_REFUSE:
            begin
                refused_next = 1'b1;
            end
            mtk_pkg::DP_PTT_OFF:
            begin
                ptt_off_next = 1'b1;
            end
            mtk_pkg::DP_FINISH:
            begin
                keyed_next   = 1'b0;
                phase_next   = mtk_pkg::PH_IDLE;
                wait_next    = '0;
                ptt_off_next = item_act_reg;
            end
            mtk_pkg::DP_WAIT_TICK:
            begin
                if (wait_reg != 7'd0)
                begin
                    wait_next = wait_reg - 7'd1;
                end
                if (wait_reg <= 7'd1)
                begin
                    phase_next    = mtk_pkg::PH_IDLE;
                    rejected_next = 1'b1;
                end
            end
            mtk_pkg::DP_KEY_LOST:
            begin
                keyed_next = 1'b0;
                phase_next = mtk_pkg::PH_IDLE;
            end
            mtk_pkg::DP_TICK_DEC:
            begin
                if (tick_reg != 8'd0)
                begin
                    tick_next = tick_reg - 8'd1;
                end
            end
            mtk_pkg::DP_MARK_END:
            begin
                keyed_next = 1'b0;
                num_next   = num_reg + 3'd1;
                if (!elem_last)
                begin
                    phase_next = mtk_pkg::PH_EGAP;
                    tick_next  = dot1;
                end
                else
                begin
                    pos_next = pos_reg + ONE_C;
                end
            end
            mtk_pkg::DP_BEGIN_ELEM:
            begin
                keyed_next = 1'b1;
                tick_next  = elem_dash ? dot3 : dot1;
                phase_next = mtk_pkg::PH_MARK;
            end
            mtk_pkg::DP_POS_INC:
            begin
                pos_next = pos_reg + ONE_C;
            end
            mtk_pkg::DP_BEGIN_CHAR:
            begin
                pattern_next = rd_morse.pattern;
                num_next     = 3'd0;
                total_next   = rd_morse.pattern[7:5] + 3'd1;
                keyed_next   = 1'b1;
                tick_next    = char_dash ? dot3 : dot1;
                phase_next   = mtk_pkg::PH_MARK;
            end
            mtk_pkg::DP_CGAP:
            begin
                phase_next = mtk_pkg::PH_CGAP;
                tick_next  = dot3;
            end
            mtk_pkg::DP_WGAP:
            begin
                phase_next = mtk_pkg::PH_WGAP;
                tick_next  = dot7;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mtk_pkg::PH_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            pattern_reg   <= '0;
            num_reg       <= '0;
            total_reg     <= '0;
            tick_reg      <= '0;
            wait_reg      <= '0;
            rejected_reg  <= 1'b0;
            keyed_reg     <= 1'b0;
            ptt_on_reg    <= 1'b0;
            ptt_off_reg   <= 1'b0;
            refused_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            pattern_reg   <= pattern_next;
            num_reg       <= num_next;
            total_reg     <= total_next;
            tick_reg      <= tick_next;
            wait_reg      <= wait_next;
            rejected_reg  <= rejected_next;
            keyed_reg     <= keyed_next;
            ptt_on_reg    <= ptt_on_next;
            ptt_off_reg   <= ptt_off_next;
            refused_reg   <= refused_next;
            if (cmd.capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_op_reg   <= s_tuser;
            item_char_reg <= s_tdata[6:0];
            item_act_reg  <= s_tdata[7];
            item_end_reg  <= s_tdata[8];
        end
        if (cmd.capture)
        begin
            out_data_reg <= {4'd0, 6'(count_reg), refused_reg, rejected_reg,
                             ptt_off_reg, ptt_on_reg,
                             (phase_reg != mtk_pkg::PH_IDLE), keyed_reg};
        end
    end

    // Read follows the next send position so the entry at the current one is on hand
    always_ff @(posedge clk)
    begin
        if (cmd.op == mtk_pkg::DP_APPEND)
        begin
            mem[count_reg[AW-1:0]] <= mtk_pkg::fold_case(item_char_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[pos_next[AW-1:0]];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.op          = item_op_reg;
    assign status.tx_active   = item_act_reg;
    assign status.tx_ended    = item_end_reg;
    assign status.phase       = phase_reg;
    assign status.count_zero  = (count_reg == '0);
    assign status.count_full  = (count_reg >= DEPTH_C);
    assign status.tick_expire = (tick_reg <= 8'd1);
    assign status.elem_last   = elem_last;
    assign status.pos_in      = (pos_reg < count_reg);
    assign status.char_valid  = rd_morse.valid;
    assign status.char_space  = (rd_data_reg == mtk_pkg::CHAR_SPACE);
    assign status.out_free    = !out_valid_reg || m_tready;

endmodule
